/* rtl/core/fspm_pkg.sv */
// Shared types, codes and defaults of the frame slot pool manager.
`timescale 1ns / 1ps
`default_nettype none
package fspm_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int DIM_W       = 13;
  localparam int PITCH_W     = 15;
  localparam int COUNT_W     = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_HEIGHT = 4'd1;

  typedef enum logic [2:0] {
    MODE_CLAIM   = 3'd0,
    MODE_RELEASE = 3'd1,
    MODE_ACQUIRE = 3'd2,
    MODE_QUERY   = 3'd3,
    MODE_FLUSH   = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] slot_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         granted_slot;
    logic               dropped;
    logic [2:0]         busy_count;
    logic [1:0]         frame_slot;
    logic               frame_valid;
    logic [DIM_W-1:0]   out_width;
    logic [DIM_W-1:0]   out_height;
    logic [PITCH_W-1:0] out_pitch;
    logic [COUNT_W-1:0] frames_done;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/fspm_ctrl.sv */
// Operation sequencer: accept, slot scan, execute.
`timescale 1ns / 1ps
`default_nettype none
module fspm_ctrl import fspm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = stat.need_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy     = busy_r;
  assign cmd.load = start && !busy_r;
  assign cmd.scan = (state_r == S_SCAN);
  assign cmd.exec = (state_r == S_EXEC);

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE)
    else $error("execute state held more than one cycle");

  a_scan_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.scan_last) |=> state_r == S_EXEC)
    else $error("scan end did not advance to execute");

endmodule
`default_nettype wire

/* rtl/core/fspm_dp.sv */
// Slot pool state, slot scan, operation update and result register.
`timescale 1ns / 1ps
`default_nettype none
module fspm_dp import fspm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire in_item_t               in_payload,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                        out_valid,
  output out_item_t                   out_payload
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX   = IW'(SLOT_COUNT - 1);
  localparam logic [4:0]    SLOT_LIMIT = 5'(SLOT_COUNT);
  localparam logic [13:0]   MAX_W14    = 14'(MAX_WIDTH);
  localparam logic [13:0]   MAX_H14    = 14'(MAX_HEIGHT);

  logic [DIM_W-1:0]    fmt_w_r, fmt_w_nxt;
  logic [DIM_W-1:0]    fmt_h_r, fmt_h_nxt;
  logic [2:0]          mode_r, mode_nxt;
  logic [2:0]          sid_r, sid_nxt;
  logic [IW-1:0]       scan_idx_r, scan_idx_nxt;
  logic                found_r, found_nxt;
  logic                found_empty_r, found_empty_nxt;
  logic [IW-1:0]       chosen_r, chosen_nxt;
  logic [COUNT_W-1:0]  best_r, best_nxt;
  logic [CW-1:0]       busy_cnt_r, busy_cnt_nxt;
  logic [SLOT_COUNT-1:0] slot_busy_r, slot_busy_nxt;
  logic [COUNT_W-1:0]  slot_order_r [SLOT_COUNT];
  logic [COUNT_W-1:0]  slot_order_nxt [SLOT_COUNT];
  logic                shown_valid_r, shown_valid_nxt;
  logic [IW-1:0]       shown_index_r, shown_index_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic [COUNT_W-1:0]  cur_order;
  logic                cur_busy;
  logic                claim_elig;
  logic                present;
  logic                fmt_set;
  logic                release_ok;
  logic [IW-1:0]       rel_idx;
  logic                acq_sv;
  logic [IW-1:0]       acq_si;

  assign cur_order  = slot_order_r[scan_idx_r];
  assign cur_busy   = slot_busy_r[scan_idx_r];
  assign claim_elig = !cur_busy && !(shown_valid_r && scan_idx_r == shown_index_r);
  assign present    = !cur_busy && (cur_order != '0);
  assign fmt_set    = (fmt_w_r != '0) && (fmt_h_r != '0);
  assign release_ok = (sid_r != 3'd0) && ({2'b00, sid_r} <= SLOT_LIMIT);
  assign rel_idx    = IW'(sid_r - 3'd1);

  assign stat.need_scan = (in_payload.mode == MODE_CLAIM) ||
                          (in_payload.mode == MODE_ACQUIRE) ||
                          (in_payload.mode == MODE_QUERY);
  assign stat.scan_last = (scan_idx_r == LAST_IDX);

  always_comb begin
    fmt_w_nxt       = fmt_w_r;
    fmt_h_nxt       = fmt_h_r;
    mode_nxt        = mode_r;
    sid_nxt         = sid_r;
    scan_idx_nxt    = scan_idx_r;
    found_nxt       = found_r;
    found_empty_nxt = found_empty_r;
    chosen_nxt      = chosen_r;
    best_nxt        = best_r;
    busy_cnt_nxt    = busy_cnt_r;
    slot_busy_nxt   = slot_busy_r;
    slot_order_nxt  = slot_order_r;
    shown_valid_nxt = shown_valid_r;
    shown_index_nxt = shown_index_r;
    count_nxt       = count_r;
    out_valid_nxt   = cmd.exec;
    out_nxt         = out_r;
    acq_sv          = shown_valid_r;
    acq_si          = shown_index_r;

    if (cfg_write) begin
      unique case (cfg_index)
        CFG_FORMAT_WIDTH: begin
          fmt_w_nxt = ({1'b0, cfg_data} > MAX_W14) ? DIM_W'(MAX_W14) : cfg_data;
        end
        CFG_FORMAT_HEIGHT: begin
          fmt_h_nxt = ({1'b0, cfg_data} > MAX_H14) ? DIM_W'(MAX_H14) : cfg_data;
        end
        default: begin
        end
      endcase
    end

    if (cmd.load) begin
      mode_nxt        = in_payload.mode;
      sid_nxt         = in_payload.slot_id;
      scan_idx_nxt    = '0;
      found_nxt       = 1'b0;
      found_empty_nxt = 1'b0;
      busy_cnt_nxt    = '0;
    end else if (cmd.scan) begin
      if (scan_idx_r != LAST_IDX) begin
        scan_idx_nxt = scan_idx_r + IW'(1);
      end
      busy_cnt_nxt = busy_cnt_r + CW'(cur_busy);
      if (mode_r == MODE_CLAIM) begin
        if (claim_elig && !found_empty_r) begin
          if (cur_order == '0) begin
            chosen_nxt      = scan_idx_r;
            found_nxt       = 1'b1;
            found_empty_nxt = 1'b1;
          end else if (!found_r || cur_order < best_r) begin
            chosen_nxt = scan_idx_r;
            best_nxt   = cur_order;
            found_nxt  = 1'b1;
          end
        end
      end else if (present && (!found_r || cur_order > best_r)) begin
        chosen_nxt = scan_idx_r;
        best_nxt   = cur_order;
        found_nxt  = 1'b1;
      end
    end

    if (cmd.exec) begin
      out_nxt = '0;
      unique case (mode_r)
        MODE_CLAIM: begin
          if (fmt_set && found_r) begin
            slot_busy_nxt[chosen_r]  = 1'b1;
            slot_order_nxt[chosen_r] = '0;
            out_nxt.granted_slot     = 3'({1'b0, chosen_r} + (IW + 1)'(1));
          end else begin
            out_nxt.dropped = 1'b1;
          end
          out_nxt.busy_count = fmt_set ? 3'(busy_cnt_r) : 3'd0;
        end
        MODE_RELEASE: begin
          if (release_ok) begin
            slot_busy_nxt[rel_idx]  = 1'b0;
            count_nxt               = count_r + COUNT_W'(1);
            slot_order_nxt[rel_idx] = count_nxt;
          end
        end
        MODE_ACQUIRE: begin
          if (found_r) begin
            acq_sv          = 1'b1;
            acq_si          = chosen_r;
            shown_valid_nxt = 1'b1;
            shown_index_nxt = chosen_r;
          end
          if (acq_sv && fmt_set) begin
            out_nxt.frame_slot  = 2'(acq_si);
            out_nxt.frame_valid = 1'b1;
            out_nxt.out_width   = fmt_w_r;
            out_nxt.out_height  = fmt_h_r;
            out_nxt.out_pitch   = {fmt_w_r, 2'b00};
          end
        end
        MODE_QUERY: begin
          if (fmt_set && (shown_valid_r || found_r)) begin
            out_nxt.frame_valid = 1'b1;
            if (shown_valid_r) begin
              out_nxt.frame_slot = 2'(shown_index_r);
            end
          end
        end
        MODE_FLUSH: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_order_nxt[i] = '0;
          end
          shown_valid_nxt = 1'b0;
          shown_index_nxt = '0;
        end
        default: begin
        end
      endcase
      out_nxt.frames_done = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_w_r       <= '0;
      fmt_h_r       <= '0;
      slot_busy_r   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_order_r[i] <= '0;
      end
      shown_valid_r <= 1'b0;
      shown_index_r <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      scan_idx_r    <= '0;
      found_r       <= 1'b0;
      found_empty_r <= 1'b0;
      busy_cnt_r    <= '0;
    end else begin
      fmt_w_r       <= fmt_w_nxt;
      fmt_h_r       <= fmt_h_nxt;
      slot_busy_r   <= slot_busy_nxt;
      slot_order_r  <= slot_order_nxt;
      shown_valid_r <= shown_valid_nxt;
      shown_index_r <= shown_index_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      scan_idx_r    <= scan_idx_nxt;
      found_r       <= found_nxt;
      found_empty_r <= found_empty_nxt;
      busy_cnt_r    <= busy_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    sid_r    <= sid_nxt;
    chosen_r <= chosen_nxt;
    best_r   <= best_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.exec))
    else $error("result strobe without execute cycle");

  a_drop_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.dropped) |-> (out_r.granted_slot == 3'd0))
    else $error("dropped claim carries a granted slot");

  a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && mode_r == MODE_RELEASE && release_ok) |=>
      (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("release did not advance the completion count");

endmodule
`default_nettype wire

/* rtl/core/frame_slot_pool_manager.sv */
// Frame slot pool manager top level: sequencer plus slot pool datapath.
// Claim, acquire and query scan every slot, then execute; busy drops in the same
// cycle that the result strobe shows. Release, flush and unknown modes skip the scan.
// A new item is taken only while busy is low, so never before the last one is done.
// The cost is the slot scan: one slot's completion number compared per cycle.
// Synchronous active-low reset clears the pool, counters and format registers.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module frame_slot_pool_manager import fspm_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire in_item_t               in_payload,
  output logic                        out_valid,
  output out_item_t                   out_payload,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  fspm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fspm_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule
`default_nettype wire
